// ===== sv/dpe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpe_pkg: shared types and constants for the damped pendulum Euler stepper
// Fixed-point widths, sequencer states, register map and the quarter-wave
// sine table built at elaboration.
// ----------------------------------------------------------------------------
package dpe_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int QUARTER         = 2 ** (SINE_TABLE_BITS - 2);
  localparam int RIDX_W          = SINE_TABLE_BITS - 1;

  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 49;
  localparam int SIN_W  = 18;

  localparam logic [31:0] TURN_PER_RAD = 32'd683565276;
  localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
  localparam logic [63:0] Q30_ONE      = 64'd1 << 30;

  localparam logic signed [ACC_W-1:0] S32_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] S32_MIN = ACC_W'(-64'sd2147483648);

  // register map, word index
  localparam logic [2:0] REG_TIME_STEP    = 3'd0;
  localparam logic [2:0] REG_GRAVITY_COEF = 3'd1;
  localparam logic [2:0] REG_DAMPING_COEF = 3'd2;
  localparam logic [2:0] REG_INIT_ANGLE   = 3'd3;
  localparam logic [2:0] REG_INIT_RATE    = 3'd4;
  localparam logic [2:0] REG_RUN_LENGTH   = 3'd5;

  localparam logic [15:0] TIME_STEP_RST    = 16'd6554;
  localparam logic [30:0] GRAVITY_COEF_RST = 31'd257163;
  localparam logic [30:0] DAMPING_COEF_RST = 31'd3277;
  localparam logic [31:0] INIT_ANGLE_RST   = 32'd98304;
  localparam logic [31:0] INIT_RATE_RST    = 32'd0;
  localparam logic [15:0] RUN_LENGTH_RST   = 16'd100;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PHASE,
    ST_SINE,
    ST_GRAV,
    ST_DAMP,
    ST_DTH,
    ST_SAT,
    ST_DW,
    ST_RATE,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    MS_PHASE,
    MS_GRAV,
    MS_DAMP,
    MS_DTH,
    MS_DW
  } mul_sel_t;

  typedef struct packed {
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     sine_en;
    logic     acc_init;
    logic     acc_sub;
    logic     sat_en;
    logic     rate_en;
    logic     commit;
  } ctrl_t;

  typedef logic [QUARTER:0][16:0] sine_tab_t;

  // sin(x) on [0, pi/2], Q2.30 in and out, truncating Taylor steps
  function automatic logic [63:0] sin_quadrant_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    return (x * t) >> 30;
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] s;
    for (int k = 0; k <= QUARTER; k++) begin
      x = (64'(k) * HALF_PI_Q30) >> (SINE_TABLE_BITS - 2);
      s = (sin_quadrant_q30(x) + (64'd1 << 13)) >> 14;
      if (s > 64'd65536) begin
        s = 64'd65536;
      end
      tab[k] = s[16:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  // clamp to the signed 32 bit range
  function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic [31:0] r;
    if (v > S32_MAX) begin
      r = 32'h7fff_ffff;
    end else if (v < S32_MIN) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/damped_pendulum_euler_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// damped_pendulum_euler_step: damped pendulum, one forward Euler step per item
// Signed Q16.16 state, table sine, one shared 33x33 multiplier.
// ----------------------------------------------------------------------------
// Each input item carries a torque and a restart flag. The block returns one
// item with the step index, angle and rate from before the update, the torque
// and a last-step flag on tlast, then advances the state. An accepted item is
// worked through until its result is loaded into the output register, and
// the input is ready again in the next cycle; a new item is taken only after
// the last one is done. An item steps in turn through phase, sine lookup,
// gravity, damping and dth, saturate, dw, rate and commit, then idle, which
// takes the next item; the five products pass through the single shared
// multiplier. A result that waits on the output holds the commit step, so
// tready stays low until the output register is free.
// Registers: 0 time_step, 1 gravity_coef, 2 damping_coef, 3 init_angle,
// 4 init_rate, 5 run_length, at byte address 4*index.
module damped_pendulum_euler_step
  import dpe_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  // input stream
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [31:0]  s_tdata,   // [31:0] torque
  input  wire logic         s_tuser,   // [0] restart
  // output stream
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [111:0]      m_tdata,   // [15:0] step_index, [47:16] angle,
                                       // [79:48] rate, [111:80] applied_torque
  output logic              m_tlast,
  // configuration
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // configuration registers
  logic [15:0] time_step;
  logic [30:0] gravity_coef;
  logic [30:0] damping_coef;
  logic [31:0] init_angle;
  logic [31:0] init_rate;
  logic [15:0] run_length;

  // pendulum state
  logic [31:0] angle_state;
  logic [31:0] rate_state;
  logic [15:0] step_counter;

  // working registers
  state_t                    state, state_next;
  ctrl_t                     ctrl;
  logic [31:0]               torque_r;
  logic                      last_r;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [SIN_W-1:0]   sin_r;
  logic signed [ACC_W-1:0]   acc;
  logic [31:0]               angle_new;
  logic [31:0]               rate_new;

  logic                      cfg_wr;
  logic                      accept;
  logic                      reload;
  logic                      out_free;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [ACC_W-1:0]   term;
  logic [31:0]               phase, phase_rnd;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [1:0]                quad;
  logic [RIDX_W-1:0]         r_fold;
  logic [16:0]               sin_mag;
  logic signed [SIN_W-1:0]   sin_val;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign reload   = s_tuser || (step_counter >= run_length);
  assign out_free = !m_tvalid || m_tready;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step    <= TIME_STEP_RST;
      gravity_coef <= GRAVITY_COEF_RST;
      damping_coef <= DAMPING_COEF_RST;
      init_angle   <= INIT_ANGLE_RST;
      init_rate    <= INIT_RATE_RST;
      run_length   <= RUN_LENGTH_RST;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_TIME_STEP:    time_step    <= pwdata[15:0];
        REG_GRAVITY_COEF: gravity_coef <= pwdata[30:0];
        REG_DAMPING_COEF: damping_coef <= pwdata[30:0];
        REG_INIT_ANGLE:   init_angle   <= pwdata;
        REG_INIT_RATE:    init_rate    <= pwdata;
        REG_RUN_LENGTH:   run_length   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_TIME_STEP:    prdata = {16'd0, time_step};
      REG_GRAVITY_COEF: prdata = {1'b0, gravity_coef};
      REG_DAMPING_COEF: prdata = {1'b0, damping_coef};
      REG_INIT_ANGLE:   prdata = init_angle;
      REG_INIT_RATE:    prdata = init_rate;
      REG_RUN_LENGTH:   prdata = {16'd0, run_length};
      default:          prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = ST_PHASE;
      ST_PHASE: state_next = ST_SINE;
      ST_SINE:  state_next = ST_GRAV;
      ST_GRAV:  state_next = ST_DAMP;
      ST_DAMP:  state_next = ST_DTH;
      ST_DTH:   state_next = ST_SAT;
      ST_SAT:   state_next = ST_DW;
      ST_DW:    state_next = ST_RATE;
      ST_RATE:  state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    ctrl.mul_sel = MS_PHASE;
    unique case (state)
      ST_PHASE: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MS_PHASE;
      end
      ST_SINE: ctrl.sine_en = 1'b1;
      ST_GRAV: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MS_GRAV;
      end
      ST_DAMP: begin
        ctrl.mul_en   = 1'b1;
        ctrl.mul_sel  = MS_DAMP;
        ctrl.acc_init = 1'b1;
      end
      ST_DTH: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MS_DTH;
        ctrl.acc_sub = 1'b1;
      end
      ST_SAT: ctrl.sat_en = 1'b1;
      ST_DW: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MS_DW;
      end
      ST_RATE: ctrl.rate_en = 1'b1;
      ST_DONE: ctrl.commit  = out_free;
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // shared multiplier
  // --------------------------------------------------------------------------
  always_comb begin
    unique case (ctrl.mul_sel)
      MS_PHASE: begin
        mul_a = {angle_state[31], angle_state};
        mul_b = {1'b0, TURN_PER_RAD};
      end
      MS_GRAV: begin
        mul_a = {2'b00, gravity_coef};
        mul_b = {{(MUL_W-SIN_W){sin_r[SIN_W-1]}}, sin_r};
      end
      MS_DAMP: begin
        mul_a = {2'b00, damping_coef};
        mul_b = {rate_state[31], rate_state};
      end
      MS_DTH: begin
        mul_a = {rate_state[31], rate_state};
        mul_b = {17'd0, time_step};
      end
      MS_DW: begin
        mul_a = acc[MUL_W-1:0];
        mul_b = {17'd0, time_step};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      mul_p <= mul_a * mul_b;
    end
  end

  // floor of the product over 2^16; every product here fits ACC_W bits after
  assign term = mul_p[16 +: ACC_W];

  // --------------------------------------------------------------------------
  // sine lookup: round phase to a table point, fold into the first quadrant
  // --------------------------------------------------------------------------
  assign phase     = mul_p[47:16];
  assign phase_rnd = phase + (32'd1 << (31 - SINE_TABLE_BITS));
  assign idx       = phase_rnd[31 -: SINE_TABLE_BITS];
  assign quad      = idx[SINE_TABLE_BITS-1 -: 2];
  assign r_fold    = quad[0] ? (RIDX_W'(QUARTER) - {1'b0, idx[SINE_TABLE_BITS-3:0]})
                             : {1'b0, idx[SINE_TABLE_BITS-3:0]};
  assign sin_mag   = SINE_TAB[r_fold];
  assign sin_val   = quad[1] ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});

  always_ff @(posedge clk) begin
    if (ctrl.sine_en) begin
      sin_r <= sin_val;
    end
  end

  // --------------------------------------------------------------------------
  // accumulate and saturate
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (ctrl.acc_init) begin
      acc <= $signed({{(ACC_W-32){torque_r[31]}}, torque_r}) - term;
    end else if (ctrl.acc_sub) begin
      acc <= acc - term;
    end else if (ctrl.sat_en) begin
      acc <= ACC_W'($signed(sat32(acc)));
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sat_en) begin
      angle_new <= sat32($signed({{(ACC_W-32){angle_state[31]}}, angle_state}) + term);
    end
    if (ctrl.rate_en) begin
      rate_new <= sat32($signed({{(ACC_W-32){rate_state[31]}}, rate_state}) + term);
    end
  end

  // --------------------------------------------------------------------------
  // state, item capture and output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_state  <= INIT_ANGLE_RST;
      rate_state   <= 32'd0;
      step_counter <= 16'd0;
    end else if (accept && reload) begin
      angle_state  <= init_angle;
      rate_state   <= init_rate;
      step_counter <= 16'd0;
    end else if (ctrl.commit) begin
      angle_state  <= angle_new;
      rate_state   <= rate_new;
      step_counter <= step_counter + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      torque_r <= s_tdata;
    end
    if (state == ST_PHASE) begin
      last_r <= ({1'b0, step_counter} + 17'd1) >= {1'b0, run_length};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      m_tdata <= {torque_r, rate_state, angle_state, step_counter};
      m_tlast <= last_r;
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("input ready right after an accepted item");

  a_sine_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_GRAV) |-> (sin_r <= 18'sd65536) && (sin_r >= -18'sd65536))
    else $error("sine out of range");

  a_hold_commit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) && m_tvalid && !m_tready |=> (state == ST_DONE) && $stable(step_counter))
    else $error("commit while output register full");

  a_last_step: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> ({1'b0, m_tdata[15:0]} + 17'd1) >= {1'b0, run_length})
    else $error("last flag before end of run");

endmodule
`default_nettype wire
